// ----- rtl/core/sacmc_pkg.sv -----
// Shared widths, register indexes, result codes and LFSR step of the cache miss classifier.
package sacmc_pkg;

   // Field widths of the request and the response.
   localparam int ADDR_W     = 32;
   localparam int TOTAL_W    = 32;
   localparam int KIND_W     = 2;
   localparam int WAY_OUT_W  = 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int IDX_BITS_W = 4;
   localparam int OFS_BITS_W = 5;
   localparam int WAYS_CFG_W = 4;

   // Shared remainder unit works on a 16-bit dividend, one bit per cycle.
   localparam int DVD_W      = 16;

   // Victim LFSR.
   localparam int LFSR_W     = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

   // Defaults of the top-level parameters.
   localparam int DEF_MAX_SETS = 256;
   localparam int DEF_MAX_WAYS = 8;

   // Register reset values.
   localparam logic [IDX_BITS_W-1:0] RST_INDEX_BITS  = 4'd8;
   localparam logic [OFS_BITS_W-1:0] RST_OFFSET_BITS = 5'd2;
   localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

   // Victim selection modes.
   localparam logic REPLACE_LFSR = 1'b0;
   localparam logic REPLACE_RR   = 1'b1;
   localparam logic RST_REPLACE  = REPLACE_RR;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INDEX_BITS   = 2'd0,
      CSR_OFFSET_BITS  = 2'd1,
      CSR_WAYS_IN_USE  = 2'd2,
      CSR_REPLACE_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT        = 2'd0,
      KIND_COMPULSORY = 2'd1,
      KIND_CAPACITY   = 2'd2
   } miss_kind_type;

   // One step of the x^16+x^14+x^13+x^11 Fibonacci LFSR, shifting right.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
      logic b;
      b = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {b, s[LFSR_W-1:1]};
   endfunction

endpackage

// ----- rtl/core/sacmc_req_if.sv -----
// Request channel of the cache miss classifier: one byte address per request.
interface sacmc_req_if import sacmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

// ----- rtl/core/sacmc_rsp_if.sv -----
// Response channel of the cache miss classifier: classification and running totals.
interface sacmc_rsp_if import sacmc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [KIND_W-1:0]    miss_kind;
   logic [WAY_OUT_W-1:0] way_used;
   logic [TOTAL_W-1:0]   hit_total;
   logic [TOTAL_W-1:0]   compulsory_total;
   logic [TOTAL_W-1:0]   capacity_total;

   modport source (output valid, output hit, output miss_kind, output way_used,
                   output hit_total, output compulsory_total, output capacity_total,
                   input ready);
   modport sink   (input valid, input hit, input miss_kind, input way_used,
                   input hit_total, input compulsory_total, input capacity_total,
                   output ready);
endinterface

// ----- rtl/core/set_assoc_cache_miss_classifier.sv -----
// Set-associative cache lookup that classifies each request as hit, compulsory or capacity miss.
//
// Usage: a request carries one 32-bit byte address on req_bus. The address is split into
// offset, set index and tag by the csr registers, the tag is looked up in the selected set
// and the response on rsp_bus reports hit, miss kind, the way used and three saturating
// totals as they stand after this request. One response per request, in order.
// Registers are written over the csr port while no request is in flight.
//
// Timing: the set index is reduced modulo MAX_SETS, by a mask for a power of two and by a
// reciprocal multiply otherwise. In LFSR mode the shared remainder unit (16-bit dividend,
// one bit per cycle) then takes the LFSR value modulo the ways in use. One tag read per
// cycle then compares the ways in order, up to the hit way, or over all the ways in use on
// a miss. req_bus.ready is high only between requests, so the next request is taken in the
// cycle after the response is registered, even while the response waits.
//
// Reset: synchronous. After reset a pass over all MAX_SETS sets clears the valid bits, one set
// per cycle, and no request is taken meanwhile. A stalled receiver holds the response;
// a finished lookup waits for the output register to free before it commits.
module set_assoc_cache_miss_classifier
   import sacmc_pkg::*;
#(
   parameter int MAX_SETS = DEF_MAX_SETS,
   parameter int MAX_WAYS = DEF_MAX_WAYS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   sacmc_req_if.sink             req_bus,
   sacmc_rsp_if.source           rsp_bus
);

   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W     = $clog2(MAX_WAYS + 1);
   localparam int DIV_W     = $clog2(MAX_WAYS + 1);
   localparam int STEP_W    = $clog2(DVD_W);
   localparam int RECIP_SH  = 32;
   localparam bit SETS_POW2 = (MAX_SETS & (MAX_SETS - 1)) == 0;
   localparam logic [RECIP_SH-1:0] SET_RECIP =
      RECIP_SH'(((64'd1 << RECIP_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_MOD,
      ST_VIC_MOD,
      ST_ISSUE,
      ST_CMP,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [IDX_BITS_W-1:0] index_bits_ff;
   logic [OFS_BITS_W-1:0] offset_bits_ff;
   logic [WAYS_CFG_W-1:0] ways_in_use_ff;
   logic                  replace_mode_ff;

   // Sequencer and datapath registers.
   state_type             state_ff;
   logic [SET_W-1:0]      clr_ff;
   logic [ADDR_W-1:0]     tag_ff;
   logic [SET_W-1:0]      set_ff;
   logic [WAY_W-1:0]      way_ff;
   logic [WAY_W-1:0]      victim_ff;
   logic [WAY_W-1:0]      ptr_ff;
   logic [LFSR_W-1:0]     lfsr_ff;
   logic                  found_ff;
   logic [DVD_W-1:0]      dvd_ff;
   logic [DIV_W-1:0]      rem_ff;
   logic [DIV_W-1:0]      dvs_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DVD_W-1:0]      quo_ff;
   logic [TOTAL_W-1:0]    hit_cnt_ff;
   logic [TOTAL_W-1:0]    comp_cnt_ff;
   logic [TOTAL_W-1:0]    cap_cnt_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic [WAY_OUT_W-1:0]  rsp_way_ff;

   // Memories and their registered read data.
   logic [ADDR_W-1:0]     tag_mem [MAX_SETS][MAX_WAYS];
   logic [MAX_WAYS-1:0]   valid_mem [MAX_SETS];
   logic [ADDR_W-1:0]     tag_rd_ff;
   logic [MAX_WAYS-1:0]   valid_rd_ff;

   // Combinational signals.
   logic [CNT_W-1:0]      ways_eff;
   logic [ADDR_W-1:0]     field_full;
   logic [DVD_W-1:0]      idx_mask;
   logic [DVD_W-1:0]      field;
   logic [5:0]            split;
   logic [ADDR_W-1:0]     req_tag;
   logic [DVD_W+RECIP_SH-1:0] quo_prod;
   logic [2*DVD_W-1:0]    quo_back;
   logic [DVD_W-1:0]      set_rem;
   logic [DIV_W:0]        cand;
   logic                  cand_ge;
   logic [DIV_W-1:0]      rem_nx;
   logic [LFSR_W-1:0]     lfsr_nx;
   logic [WAY_W-1:0]      rr_victim;
   logic [CNT_W-1:0]      rr_inc;
   logic [WAY_W-1:0]      rr_next;
   logic [CNT_W-1:0]      way_inc;
   logic                  last_way;
   logic                  hit_now;
   logic [WAY_W-1:0]      tag_rd_way;
   logic                  fin_go;
   logic                  is_comp;
   logic [MAX_WAYS-1:0]   victim_bit;
   logic [WAY_W-1:0]      way_result;
   logic                  clr_last;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff   <= RST_INDEX_BITS;
         offset_bits_ff  <= RST_OFFSET_BITS;
         ways_in_use_ff  <= RST_WAYS_IN_USE;
         replace_mode_ff <= RST_REPLACE;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INDEX_BITS:   index_bits_ff   <= csr_wdata[IDX_BITS_W-1:0];
            CSR_OFFSET_BITS:  offset_bits_ff  <= csr_wdata[OFS_BITS_W-1:0];
            CSR_WAYS_IN_USE:  ways_in_use_ff  <= csr_wdata[WAYS_CFG_W-1:0];
            CSR_REPLACE_MODE: replace_mode_ff <= csr_wdata[0];
         endcase
      end
   end

   // Ways in effect: zero acts as one, values above MAX_WAYS saturate.
   always_comb begin
      if (ways_in_use_ff == '0) begin
         ways_eff = CNT_W'(1);
      end else if ({1'b0, ways_in_use_ff} > (WAYS_CFG_W + 1)'(MAX_WAYS)) begin
         ways_eff = CNT_W'(MAX_WAYS);
      end else begin
         ways_eff = CNT_W'(ways_in_use_ff);
      end
   end

   // Address split into index field and tag.
   assign field_full = req_bus.address >> offset_bits_ff;
   assign idx_mask   = ~({DVD_W{1'b1}} << index_bits_ff);
   assign field      = field_full[DVD_W-1:0] & idx_mask;
   assign split      = {1'b0, offset_bits_ff} + {2'b00, index_bits_ff};
   assign req_tag    = split[5] ? '0 : (req_bus.address >> split[4:0]);

   // Set index modulo MAX_SETS: the quotient by reciprocal is registered, the remainder follows in the next cycle.
   assign quo_prod = (DVD_W+RECIP_SH)'(dvd_ff) * (DVD_W+RECIP_SH)'(SET_RECIP);
   assign quo_back = (2*DVD_W)'(quo_ff) * (2*DVD_W)'(MAX_SETS);
   assign set_rem  = SETS_POW2 ? (dvd_ff & DVD_W'(MAX_SETS - 1))
                               : (dvd_ff - quo_back[DVD_W-1:0]);

   // Shared remainder unit: one restoring step per cycle.
   assign cand    = {rem_ff, dvd_ff[DVD_W-1]};
   assign cand_ge = cand >= {1'b0, dvs_ff};
   assign rem_nx  = cand_ge ? DIV_W'(cand - {1'b0, dvs_ff}) : cand[DIV_W-1:0];

   // Victim choice.
   assign lfsr_nx   = lfsr_next(lfsr_ff);
   assign rr_victim = (CNT_W'(ptr_ff) < ways_eff) ? ptr_ff : '0;
   assign rr_inc    = CNT_W'(rr_victim) + CNT_W'(1);
   assign rr_next   = (rr_inc >= ways_eff) ? '0 : WAY_W'(rr_inc);

   // Way compare against the tag read in the previous cycle.
   assign way_inc    = CNT_W'(way_ff) + CNT_W'(1);
   assign last_way   = way_inc >= ways_eff;
   assign hit_now    = valid_rd_ff[way_ff] && (tag_rd_ff == tag_ff);
   assign tag_rd_way = (state_ff == ST_CMP && !last_way) ? WAY_W'(way_inc) : '0;

   // Commit of a finished lookup.
   assign fin_go     = !rsp_valid_ff || rsp_bus.ready;
   assign is_comp    = !valid_rd_ff[victim_ff];
   assign victim_bit = MAX_WAYS'(1) << victim_ff;
   assign way_result = found_ff ? way_ff : victim_ff;
   assign clr_last   = clr_ff == SET_W'(MAX_SETS - 1);

   // Sequencer, counters and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         lfsr_ff      <= LFSR_SEED;
         hit_cnt_ff   <= '0;
         comp_cnt_ff  <= '0;
         cap_cnt_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + SET_W'(1);
               if (clr_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_bus.valid) begin
                  tag_ff   <= req_tag;
                  dvd_ff   <= field;
                  step_ff  <= STEP_W'(1);
                  state_ff <= ST_SET_MOD;
               end
            end
            ST_SET_MOD: begin
               quo_ff  <= quo_prod[DVD_W+RECIP_SH-1:RECIP_SH];
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  set_ff <= SET_W'(set_rem);
                  if (replace_mode_ff == REPLACE_LFSR) begin
                     lfsr_ff  <= lfsr_nx;
                     dvd_ff   <= lfsr_nx;
                     rem_ff   <= '0;
                     dvs_ff   <= DIV_W'(ways_eff);
                     step_ff  <= STEP_W'(DVD_W - 1);
                     state_ff <= ST_VIC_MOD;
                  end else begin
                     victim_ff <= rr_victim;
                     ptr_ff    <= rr_next;
                     state_ff  <= ST_ISSUE;
                  end
               end
            end
            ST_VIC_MOD: begin
               rem_ff  <= rem_nx;
               dvd_ff  <= dvd_ff << 1;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  victim_ff <= WAY_W'(rem_nx);
                  state_ff  <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               way_ff   <= '0;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (hit_now) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_FINISH;
               end else if (last_way) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_FINISH;
               end else begin
                  way_ff <= WAY_W'(way_inc);
               end
            end
            ST_FINISH: begin
               if (fin_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= found_ff;
                  rsp_way_ff   <= WAY_OUT_W'(way_result);
                  if (found_ff) begin
                     rsp_kind_ff <= KIND_HIT;
                     if (!(&hit_cnt_ff)) begin
                        hit_cnt_ff <= hit_cnt_ff + TOTAL_W'(1);
                     end
                  end else if (is_comp) begin
                     rsp_kind_ff <= KIND_COMPULSORY;
                     if (!(&comp_cnt_ff)) begin
                        comp_cnt_ff <= comp_cnt_ff + TOTAL_W'(1);
                     end
                  end else begin
                     rsp_kind_ff <= KIND_CAPACITY;
                     if (!(&cap_cnt_ff)) begin
                        cap_cnt_ff <= cap_cnt_ff + TOTAL_W'(1);
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Tag memory: one read per cycle during the way walk, filled on a miss.
   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && fin_go && !found_ff) begin
         tag_mem[set_ff][victim_ff] <= tag_ff;
      end
      tag_rd_ff <= tag_mem[set_ff][tag_rd_way];
   end

   // Valid memory: one row per set, cleared after reset, set on a compulsory miss.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         valid_mem[clr_ff] <= '0;
      end else if (state_ff == ST_FINISH && fin_go && !found_ff && is_comp) begin
         valid_mem[set_ff] <= valid_rd_ff | victim_bit;
      end
      if (state_ff == ST_ISSUE) begin
         valid_rd_ff <= valid_mem[set_ff];
      end
   end

   // Channel outputs.
   assign req_bus.ready            = state_ff == ST_IDLE;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.hit              = rsp_hit_ff;
   assign rsp_bus.miss_kind        = rsp_kind_ff;
   assign rsp_bus.way_used         = rsp_way_ff;
   assign rsp_bus.hit_total        = hit_cnt_ff;
   assign rsp_bus.compulsory_total = comp_cnt_ff;
   assign rsp_bus.capacity_total   = cap_cnt_ff;

endmodule

// ----- rtl/core/sacmc_checker.sv -----
// Port-level assertions of the cache miss classifier and their bind to the top level.
module sacmc_checker
   import sacmc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 hit,
   input logic [KIND_W-1:0]    miss_kind,
   input logic [WAY_OUT_W-1:0] way_used,
   input logic [TOTAL_W-1:0]   hit_total,
   input logic [TOTAL_W-1:0]   compulsory_total,
   input logic [TOTAL_W-1:0]   capacity_total
);

   // A response stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({hit, miss_kind, way_used, hit_total,
                                           compulsory_total, capacity_total}))
      else $error("response payload changed while stalled");

   // The hit flag and the miss kind agree, and the miss kind is one of the three defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (hit == (miss_kind == KIND_HIT)) &&
                    (miss_kind == KIND_HIT || miss_kind == KIND_COMPULSORY ||
                     miss_kind == KIND_CAPACITY))
      else $error("hit flag and miss kind disagree");

   // The total of the reported kind already counts this request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (miss_kind == KIND_HIT && hit_total != '0) ||
                    (miss_kind == KIND_COMPULSORY && compulsory_total != '0) ||
                    (miss_kind == KIND_CAPACITY && capacity_total != '0))
      else $error("total of the reported kind is zero");

   // The valid-bit clearing pass holds off requests right after reset.
   assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

endmodule

bind set_assoc_cache_miss_classifier sacmc_checker u_sacmc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .hit              (rsp_bus.hit),
   .miss_kind        (rsp_bus.miss_kind),
   .way_used         (rsp_bus.way_used),
   .hit_total        (rsp_bus.hit_total),
   .compulsory_total (rsp_bus.compulsory_total),
   .capacity_total   (rsp_bus.capacity_total)
);

// ----- tb/sv/set_assoc_cache_miss_classifier_tb.sv -----
// Self-checking testbench of the set-associative cache miss classifier.
module set_assoc_cache_miss_classifier_tb;
   import sacmc_pkg::*;

   localparam int SET_COUNT    = DEF_MAX_SETS;
   localparam int WAY_COUNT    = DEF_MAX_WAYS;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_COUNT  = 10;
   localparam int FIXED_PHASES = 6;
   localparam int PHASE_ITEMS  = 113;
   localparam int POOL_SIZE    = 16;

   // Fixed register settings of the first random phases, in register index order:
   // index_bits, offset_bits, ways_in_use, replace_mode.
   localparam logic [CSR_DATA_W-1:0] PHASE_SETTING [FIXED_PHASES][4] = '{
      '{5'd8,  5'd2,  5'd1, 5'd1},
      '{5'd4,  5'd6,  5'd4, 5'd1},
      '{5'd2,  5'd4,  5'd8, 5'd0},
      '{5'd0,  5'd0,  5'd3, 5'd0},
      '{5'd15, 5'd17, 5'd8, 5'd1},
      '{5'd9,  5'd31, 5'd5, 5'd0}
   };

   typedef struct packed {
      logic                 hit;
      miss_kind_type        kind;
      logic [WAY_OUT_W-1:0] way;
      logic [TOTAL_W-1:0]   hits;
      logic [TOTAL_W-1:0]   compulsory;
      logic [TOTAL_W-1:0]   capacity;
   } lookup_type;

   typedef enum logic {ROW_WRITE, ROW_LOOKUP} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      csr_index_type         sel;
      logic [CSR_DATA_W-1:0] data;
      logic [ADDR_W-1:0]     addr;
      bit                    typed;
      lookup_type            want;
   } stim_row_type;

   bit                    clock;
   bit                    reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sacmc_req_if req_bus ();
   sacmc_rsp_if rsp_bus ();

   set_assoc_cache_miss_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // Shadow copy of the cache and its registers.
   logic [IDX_BITS_W-1:0] cfg_index;
   logic [OFS_BITS_W-1:0] cfg_offset;
   logic [WAYS_CFG_W-1:0] cfg_ways;
   logic                  cfg_mode;
   bit                    line_valid [SET_COUNT*WAY_COUNT];
   logic [ADDR_W-1:0]     line_tag [SET_COUNT*WAY_COUNT];
   int unsigned           rr_ptr;
   logic [LFSR_W-1:0]     victim_lfsr;
   logic [TOTAL_W-1:0]    hit_count;
   logic [TOTAL_W-1:0]    compulsory_count;
   logic [TOTAL_W-1:0]    capacity_count;

   lookup_type  awaited_results [$];
   int unsigned errors;
   int unsigned lookup_count;
   int unsigned write_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Classify one address against the shadow cache and update it.
   task automatic predict_lookup(input logic [ADDR_W-1:0] addr, output lookup_type r);
      logic [63:0]       field;
      logic [ADDR_W-1:0] tag;
      int unsigned       ways, split, base, victim, way;
      bit                found;
      ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_COUNT) ? WAY_COUNT : cfg_ways);
      split = cfg_offset + cfg_index;
      field = ({32'd0, addr} >> cfg_offset) & ((64'd1 << cfg_index) - 64'd1);
      base = (field % SET_COUNT) * WAY_COUNT;
      tag = (split >= ADDR_W) ? '0 : addr >> split;

      // Victim choice advances on every access, hit or miss.
      if (cfg_mode == REPLACE_RR) begin
         victim = (rr_ptr < ways) ? rr_ptr : 0;
         rr_ptr = (victim + 1 >= ways) ? 0 : victim + 1;
      end else begin
         victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                        victim_lfsr[LFSR_W-1:1]};
         victim = victim_lfsr % ways;
      end

      found = 1'b0;
      way = 0;
      for (int w = 0; w < ways && !found; w++) begin
         if (line_valid[base+w] && line_tag[base+w] == tag) begin
            found = 1'b1;
            way = w;
         end
      end

      // Hits count; misses fill the victim and are told apart by its valid bit.
      if (found) begin
         if (hit_count != '1) hit_count++;
         r.kind = KIND_HIT;
      end else begin
         way = victim;
         if (!line_valid[base+victim]) begin
            if (compulsory_count != '1) compulsory_count++;
            line_valid[base+victim] = 1'b1;
            r.kind = KIND_COMPULSORY;
         end else begin
            if (capacity_count != '1) capacity_count++;
            r.kind = KIND_CAPACITY;
         end
         line_tag[base+victim] = tag;
      end
      r.hit = found;
      r.way = WAY_OUT_W'(way);
      r.hits = hit_count;
      r.compulsory = compulsory_count;
      r.capacity = capacity_count;
      lookup_count++;
   endtask

   function automatic stim_row_type write_row(input csr_index_type sel,
                                              input logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r = '{kind: ROW_WRITE, sel: sel, data: data, addr: '0, typed: 1'b0, want: '0};
      return r;
   endfunction

   function automatic stim_row_type lookup_row(input logic [ADDR_W-1:0] addr);
      stim_row_type r;
      r = '{kind: ROW_LOOKUP, sel: CSR_INDEX_BITS, data: '0, addr: addr, typed: 1'b0,
            want: '0};
      return r;
   endfunction

   // Lookup whose outcome is written out by hand.
   function automatic stim_row_type known_row(input logic [ADDR_W-1:0] addr,
                                              input miss_kind_type kind,
                                              input int unsigned way, hits, comp, cap);
      stim_row_type r;
      r = lookup_row(addr);
      r.typed = 1'b1;
      r.want.hit = (kind == KIND_HIT);
      r.want.kind = kind;
      r.want.way = WAY_OUT_W'(way);
      r.want.hits = hits;
      r.want.compulsory = comp;
      r.want.capacity = cap;
      return r;
   endfunction

   // Address whose set falls in a small group, so that tags fight over the ways.
   function automatic logic [ADDR_W-1:0] conflict_address();
      logic [63:0] a, set_val, fmask;
      fmask = (64'd1 << cfg_index) - 64'd1;
      set_val = $urandom_range(3) + SET_COUNT * $urandom_range(1);
      a = $urandom();
      a = (a & ~(fmask << cfg_offset)) | ((set_val & fmask) << cfg_offset);
      return a[ADDR_W-1:0];
   endfunction

   // One register write; the shadow registers follow at once since the block is idle.
   task automatic write_register(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      case (sel)
         CSR_INDEX_BITS:   cfg_index = value[IDX_BITS_W-1:0];
         CSR_OFFSET_BITS:  cfg_offset = value[OFS_BITS_W-1:0];
         CSR_WAYS_IN_USE:  cfg_ways = value[WAYS_CFG_W-1:0];
         CSR_REPLACE_MODE: cfg_mode = value[0];
         default: ;
      endcase
      write_count++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop valid and wait until every request has been answered.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Present one request, hold it until taken, then queue its outcome.
   task automatic send_lookup(input logic [ADDR_W-1:0] addr, input bit typed,
                              input lookup_type want);
      lookup_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      predict_lookup(addr, pred);
      awaited_results.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic [TOTAL_W-1:0] want, got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Response check and handshake watchdog.
   always @(posedge clock) begin
      lookup_type got, want;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;

         if (rsp_bus.valid && rsp_bus.ready) begin
            got.hit = rsp_bus.hit;
            got.kind = miss_kind_type'(rsp_bus.miss_kind);
            got.way = rsp_bus.way_used;
            got.hits = rsp_bus.hit_total;
            got.compulsory = rsp_bus.compulsory_total;
            got.capacity = rsp_bus.capacity_total;
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t: response with no request outstanding, expected none, actual %p",
                        $time, got);
            end else begin
               want = awaited_results.pop_front();
               compare_field("hit", want.hit, got.hit);
               compare_field("miss_kind", want.kind, got.kind);
               compare_field("way_used", want.way, got.way);
               compare_field("hit_total", want.hits, got.hits);
               compare_field("compulsory_total", want.compulsory, got.compulsory);
               compare_field("capacity_total", want.capacity, got.capacity);
            end
         end

         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("set_assoc_cache_miss_classifier verification failed");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type          rows [$];
      logic [ADDR_W-1:0]     pool [POOL_SIZE];
      logic [ADDR_W-1:0]     addr;
      logic [CSR_DATA_W-1:0] setting [4];
      logic [63:0]           low_mask;
      int unsigned           pick;

      // Known values on every input, reset held.
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.address = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 53;

      // Shadow state after reset.
      cfg_index = RST_INDEX_BITS;
      cfg_offset = RST_OFFSET_BITS;
      cfg_ways = RST_WAYS_IN_USE;
      cfg_mode = RST_REPLACE;
      rr_ptr = 0;
      victim_lfsr = LFSR_SEED;
      hit_count = '0;
      compulsory_count = '0;
      capacity_count = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset setting first, then the corner cases of the split,
      // the way count and the victim choice.
      rows.push_back(known_row(32'h0000_0000, KIND_COMPULSORY, 0, 0, 1, 0));
      rows.push_back(known_row(32'h0000_0000, KIND_HIT,        0, 1, 1, 0));
      rows.push_back(known_row(32'hFFFF_FFFF, KIND_COMPULSORY, 0, 1, 2, 0));
      rows.push_back(known_row(32'hFFFF_FC00, KIND_CAPACITY,   0, 1, 2, 1));
      rows.push_back(known_row(32'h0000_0003, KIND_CAPACITY,   0, 1, 2, 2));
      rows.push_back(known_row(32'hFFFF_FFFC, KIND_HIT,        0, 2, 2, 2));
      // Round robin over four ways, then fewer ways leave the pointer out of range.
      rows.push_back(write_row(CSR_WAYS_IN_USE, 5'd4));
      rows.push_back(lookup_row(32'h0000_0400));
      rows.push_back(lookup_row(32'h0000_0800));
      rows.push_back(lookup_row(32'h0000_0C00));
      rows.push_back(write_row(CSR_WAYS_IN_USE, 5'd2));
      rows.push_back(lookup_row(32'h0000_1000));
      rows.push_back(lookup_row(32'h0000_0000));
      // A zero way count acts as one; a count above the maximum saturates.
      rows.push_back(write_row(CSR_WAYS_IN_USE, 5'h10));
      rows.push_back(lookup_row(32'h0000_1400));
      rows.push_back(write_row(CSR_WAYS_IN_USE, 5'h0F));
      rows.push_back(lookup_row(32'h0000_1800));
      rows.push_back(lookup_row(32'h0000_0400));
      // Pseudo-random victims.
      rows.push_back(write_row(CSR_REPLACE_MODE, 5'h1E));
      rows.push_back(lookup_row(32'h0000_2000));
      rows.push_back(lookup_row(32'h0000_2400));
      rows.push_back(lookup_row(32'h0000_2800));
      // Index wider than the set count aliases onto low sets.
      rows.push_back(write_row(CSR_INDEX_BITS, 5'h1F));
      rows.push_back(write_row(CSR_OFFSET_BITS, 5'd0));
      rows.push_back(lookup_row(32'hFFFF_FFFF));
      rows.push_back(lookup_row(32'h0001_FF00));
      // Offset and index reach past the address: the tag is zero.
      rows.push_back(write_row(CSR_OFFSET_BITS, 5'h1F));
      rows.push_back(write_row(CSR_INDEX_BITS, 5'd8));
      rows.push_back(lookup_row(32'h8000_0000));
      rows.push_back(lookup_row(32'h7FFF_FFFF));
      // No index bits: a single set.
      rows.push_back(write_row(CSR_INDEX_BITS, 5'd0));
      rows.push_back(write_row(CSR_OFFSET_BITS, 5'd16));
      rows.push_back(lookup_row(32'hABCD_1234));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_register(rows[i].sel, rows[i].data);
         end else begin
            send_lookup(rows[i].addr, rows[i].typed, rows[i].want);
         end
      end

      // Random phases: each picks a setting, then mostly reuses a small address pool.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 4) begin
            send_idle_pct = 53;
            recv_idle_pct = 31;
         end else if (p == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_idle();
         foreach (setting[r]) begin
            setting[r] = (p < FIXED_PHASES) ? PHASE_SETTING[p][r]
                                            : CSR_DATA_W'($urandom_range(31));
         end
         write_register(CSR_INDEX_BITS, setting[CSR_INDEX_BITS]);
         write_register(CSR_OFFSET_BITS, setting[CSR_OFFSET_BITS]);
         write_register(CSR_WAYS_IN_USE, setting[CSR_WAYS_IN_USE]);
         write_register(CSR_REPLACE_MODE, setting[CSR_REPLACE_MODE]);
         low_mask = (64'd1 << cfg_offset) - 64'd1;
         foreach (pool[j]) pool[j] = conflict_address();

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) pool[$urandom_range(POOL_SIZE-1)] = conflict_address();
            if (pick < 85)
               addr = pool[$urandom_range(POOL_SIZE-1)] ^ ADDR_W'($urandom() & low_mask);
            else
               addr = $urandom();
            send_lookup(addr, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      errors += awaited_results.size();

      $display("Run covered %0d lookups and %0d register writes in both victim modes.",
               lookup_count, write_count);
      $display("Outcomes: %0d hits, %0d compulsory misses, %0d capacity misses, %0d errors.",
               hit_count, compulsory_count, capacity_count, errors);
      if (errors == 0)
         $display("set_assoc_cache_miss_classifier verification clean");
      else
         $display("set_assoc_cache_miss_classifier verification failed");
      $finish;
   end

endmodule
